/* design/cau_pkg.sv */
// Shared types and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;

   // Operation codes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_CONJ = 3'd4;
   localparam logic [2:0] OP_CMP  = 3'd5;

   // Input queue geometry
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   // Quotient bits produced by the divider pipeline
   localparam int DIV_STEPS = 33;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // Execution path chosen by the front end
   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   // One queued beat
   typedef struct packed {
      logic [2:0]         op;
      kind_type           kind;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } item_type;

   // One finished result
   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        eq;
      logic        dz;
      logic        ov;
   } res_type;

   // Long-division state of one lane
   typedef struct packed {
      logic [64:0] rem;
      logic [32:0] low;
      logic [32:0] q;
      logic [63:0] den;
   } dstep_type;

endpackage
`default_nettype wire

/* design/cau_front.sv */
// Front end: accepts request beats, classifies them and queues them.
`default_nettype none
module cau_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [2:0]            req_operation,
   input  wire signed [31:0]    req_a_re,
   input  wire signed [31:0]    req_a_im,
   input  wire signed [31:0]    req_b_re,
   input  wire signed [31:0]    req_b_im,
   input  wire                  pop,
   output logic                 head_valid,
   output cau_pkg::item_type    head
);

   cau_pkg::item_type            mem_ff [cau_pkg::Q_DEPTH];
   logic [cau_pkg::Q_AW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [cau_pkg::Q_AW:0]       count_ff, count_in;
   cau_pkg::item_type            item;
   logic                         wr;

   // Classify the incoming beat
   always_comb begin
      item.op   = req_operation;
      item.a_re = req_a_re;
      item.a_im = req_a_im;
      item.b_re = req_b_re;
      item.b_im = req_b_im;
      item.kind = cau_pkg::KIND_SIMPLE;
      if (req_operation == cau_pkg::OP_MUL) begin
         item.kind = cau_pkg::KIND_MUL;
      end else if (req_operation == cau_pkg::OP_DIV &&
                   (req_b_re != 32'sd0 || req_b_im != 32'sd0)) begin
         item.kind = cau_pkg::KIND_DIV;
      end
   end

   assign req_ready  = (count_ff != (cau_pkg::Q_AW+1)'(cau_pkg::Q_DEPTH));
   assign wr         = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wptr_in  = wr  ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (wr && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

/* design/cau_div_step.sv */
// One registered restoring-division step producing one quotient bit.
`default_nettype none
module cau_div_step (
   input  wire                  clock,
   input  wire                  en,
   input  cau_pkg::dstep_type   d_in,
   output cau_pkg::dstep_type   d_out
);

   cau_pkg::dstep_type d_ff, d_in_next;
   logic [64:0]        r;
   logic               ge;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      r  = {d_in.rem[63:0], d_in.low[32]};
      ge = (r >= {1'b0, d_in.den});
      d_in_next.rem = ge ? r - {1'b0, d_in.den} : r;
      d_in_next.low = {d_in.low[31:0], 1'b0};
      d_in_next.q   = {d_in.q[31:0], ge};
      d_in_next.den = d_in.den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

   assign d_out = d_ff;

endmodule
`default_nettype wire

/* design/cau_back.sv */
// Back end: multiply, sum, split, divide and saturate pipeline.
`default_nettype none
module cau_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  cau_pkg::item_type    head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output cau_pkg::res_type     rsp
);

   localparam int NS = cau_pkg::DIV_STEPS;
   localparam int SH = cau_pkg::DIV_STEPS - FRAC_BITS;

   typedef struct packed {
      cau_pkg::kind_type kind;
      cau_pkg::res_type  res;
      logic              neg_re;
      logic              neg_im;
      logic              huge_re;
      logic              huge_im;
   } side_type;

   // Saturate a 33-bit signed sum: {ov, value}
   function automatic logic [32:0] sat33(input logic [32:0] s);
      logic [32:0] r;
      begin
         r = {1'b0, s[31:0]};
         if (s[32] != s[31]) begin
            r = {1'b1, s[32] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX};
         end
         return r;
      end
   endfunction

   // Clamp sign and magnitude to 32 bits signed: {ov, value}
   function automatic logic [32:0] clamp(input logic neg, input logic [63:0] mag,
                                         input logic huge);
      logic [32:0] r;
      logic [63:0] n;
      begin
         n = 64'd0 - mag;
         if (!neg) begin
            r = (huge || mag > 64'h7FFF_FFFF) ? {1'b1, cau_pkg::SAT_MAX}
                                              : {1'b0, mag[31:0]};
         end else begin
            r = (huge || mag > 64'h8000_0000) ? {1'b1, cau_pkg::SAT_MIN}
                                              : {1'b0, n[31:0]};
         end
         return r;
      end
   endfunction

   logic en;

   // Stage 1: products and simple results
   logic                v1_ff;
   cau_pkg::kind_type   k1_ff;
   cau_pkg::res_type    r1_ff, r1_in;
   logic signed [63:0]  p_ac_ff, p_bd_ff, p_ad_ff, p_bc_ff, p_cc_ff, p_dd_ff;
   logic [32:0]         s_a, s_b;

   // Stage 2: sums
   logic                v2_ff;
   cau_pkg::kind_type   k2_ff;
   cau_pkg::res_type    r2_ff;
   logic [63:0]         sr_ff, si_ff, den2_ff, sr_in, si_in;

   // Stage 3: sign and magnitude
   logic                v3_ff;
   cau_pkg::kind_type   k3_ff;
   cau_pkg::res_type    r3_ff;
   logic [63:0]         mr_ff, mi_ff, den3_ff;
   logic                nr_ff, ni_ff;

   // Stage 4 and divider lanes
   logic                vd_ff [NS+1];
   side_type            sd_ff [NS+1];
   side_type            sd0_in;
   cau_pkg::dstep_type  lre [NS+1];
   cau_pkg::dstep_type  lim [NS+1];
   cau_pkg::dstep_type  lre0_ff, lim0_ff, lre0_in, lim0_in;
   logic [63:0]         hre, him, shr, shi, mshr, mshi;
   logic [32:0]         cre, cim;

   // Output register
   logic                out_valid_ff;
   cau_pkg::res_type    out_ff, out_in;
   logic [32:0]         fre, fim;

   assign en  = !out_valid_ff || rsp_ready;
   assign pop = head_valid && en;

   // Compute add, subtract, conjugate, compare and zero-divisor results
   always_comb begin
      r1_in = '0;
      s_a   = '0;
      s_b   = '0;
      case (head.op)
         cau_pkg::OP_ADD: begin
            s_a = sat33({head.a_re[31], head.a_re} + {head.b_re[31], head.b_re});
            s_b = sat33({head.a_im[31], head.a_im} + {head.b_im[31], head.b_im});
            r1_in.re = s_a[31:0];
            r1_in.im = s_b[31:0];
            r1_in.ov = s_a[32] | s_b[32];
         end
         cau_pkg::OP_SUB: begin
            s_a = sat33({head.a_re[31], head.a_re} - {head.b_re[31], head.b_re});
            s_b = sat33({head.a_im[31], head.a_im} - {head.b_im[31], head.b_im});
            r1_in.re = s_a[31:0];
            r1_in.im = s_b[31:0];
            r1_in.ov = s_a[32] | s_b[32];
         end
         cau_pkg::OP_DIV: begin
            if (head.kind == cau_pkg::KIND_SIMPLE) begin
               r1_in.re = head.a_re;
               r1_in.im = head.a_im;
               r1_in.dz = 1'b1;
            end
         end
         cau_pkg::OP_CONJ: begin
            s_b = sat33(33'd0 - {head.a_im[31], head.a_im});
            r1_in.re = head.a_re;
            r1_in.im = s_b[31:0];
            r1_in.ov = s_b[32];
         end
         cau_pkg::OP_CMP: begin
            r1_in.eq = (head.a_re == head.b_re) && (head.a_im == head.b_im);
         end
         default: begin
            r1_in = '0;
         end
      endcase
   end

   // Form the cross sums
   always_comb begin
      if (k1_ff == cau_pkg::KIND_MUL) begin
         sr_in = 64'(p_ac_ff) - 64'(p_bd_ff);
         si_in = 64'(p_ad_ff) + 64'(p_bc_ff);
      end else begin
         sr_in = 64'(p_ac_ff) + 64'(p_bd_ff);
         si_in = 64'(p_bc_ff) - 64'(p_ad_ff);
      end
   end

   // Prepare the product result and the dividend of each lane
   always_comb begin
      shr  = mr_ff >> FRAC_BITS;
      shi  = mi_ff >> FRAC_BITS;
      hre  = mr_ff >> SH;
      him  = mi_ff >> SH;
      mshr = mr_ff << FRAC_BITS;
      mshi = mi_ff << FRAC_BITS;
      cre  = clamp(nr_ff, shr, 1'b0);
      cim  = clamp(ni_ff, shi, 1'b0);

      sd0_in.kind    = k3_ff;
      sd0_in.res     = r3_ff;
      sd0_in.neg_re  = nr_ff;
      sd0_in.neg_im  = ni_ff;
      sd0_in.huge_re = (hre >= den3_ff);
      sd0_in.huge_im = (him >= den3_ff);
      if (k3_ff == cau_pkg::KIND_MUL) begin
         sd0_in.res.re = cre[31:0];
         sd0_in.res.im = cim[31:0];
         sd0_in.res.ov = cre[32] | cim[32];
      end

      lre0_in.rem = {1'b0, hre};
      lre0_in.low = mshr[32:0];
      lre0_in.q   = '0;
      lre0_in.den = den3_ff;
      lim0_in.rem = {1'b0, him};
      lim0_in.low = mshi[32:0];
      lim0_in.q   = '0;
      lim0_in.den = den3_ff;
   end

   // Advance control through the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Advance payload through the front stages
   always_ff @(posedge clock) begin
      if (en) begin
         k1_ff   <= head.kind;
         r1_ff   <= r1_in;
         p_ac_ff <= 64'(head.a_re) * 64'(head.b_re);
         p_bd_ff <= 64'(head.a_im) * 64'(head.b_im);
         p_ad_ff <= 64'(head.a_re) * 64'(head.b_im);
         p_bc_ff <= 64'(head.a_im) * 64'(head.b_re);
         p_cc_ff <= 64'(head.b_re) * 64'(head.b_re);
         p_dd_ff <= 64'(head.b_im) * 64'(head.b_im);

         k2_ff   <= k1_ff;
         r2_ff   <= r1_ff;
         sr_ff   <= sr_in;
         si_ff   <= si_in;
         den2_ff <= 64'(p_cc_ff) + 64'(p_dd_ff);

         k3_ff   <= k2_ff;
         r3_ff   <= r2_ff;
         den3_ff <= den2_ff;
         nr_ff   <= sr_ff[63] && (sr_ff[62:0] != '0);
         ni_ff   <= si_ff[63] && (si_ff[62:0] != '0);
         mr_ff   <= (sr_ff[63] && (sr_ff[62:0] != '0)) ? 64'd0 - sr_ff : sr_ff;
         mi_ff   <= (si_ff[63] && (si_ff[62:0] != '0)) ? 64'd0 - si_ff : si_ff;

         lre0_ff <= lre0_in;
         lim0_ff <= lim0_in;
      end
   end

   assign lre[0] = lre0_ff;
   assign lim[0] = lim0_ff;

   // Hold side information alongside the divider lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v3_ff;
         for (int i = 1; i <= NS; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= sd0_in;
         for (int i = 1; i <= NS; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   // Divider lanes, one quotient bit per stage
   for (genvar g = 0; g < NS; g++) begin : g_div
      cau_div_step u_re (
         .clock (clock),
         .en    (en),
         .d_in  (lre[g]),
         .d_out (lre[g+1])
      );
      cau_div_step u_im (
         .clock (clock),
         .en    (en),
         .d_in  (lim[g]),
         .d_out (lim[g+1])
      );
   end

   // Saturate quotients and pick the final result
   always_comb begin
      fre    = clamp(sd_ff[NS].neg_re, {31'd0, lre[NS].q}, sd_ff[NS].huge_re);
      fim    = clamp(sd_ff[NS].neg_im, {31'd0, lim[NS].q}, sd_ff[NS].huge_im);
      out_in = sd_ff[NS].res;
      if (sd_ff[NS].kind == cau_pkg::KIND_DIV) begin
         out_in.re = fre[31:0];
         out_in.im = fim[31:0];
         out_in.ov = fre[32] | fim[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vd_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule
`default_nettype wire

/* design/complex_arithmetic_unit.sv */
// Throughput: one beat per cycle while the response is not stalled; the 33-stage
// divider pipeline, one quotient bit per stage, sets the depth, and all operations
// share the same path.
// A four-entry queue parts the front end from the pipeline.
// Reset clears the queue pointers, the fill count and all stage valid bits; no data is cleared.
`default_nettype none
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire [2:0]          req_operation,
   input  wire signed [31:0]  req_a_re,
   input  wire signed [31:0]  req_a_im,
   input  wire signed [31:0]  req_b_re,
   input  wire signed [31:0]  req_b_im,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_equal,
   output logic               rsp_div_by_zero,
   output logic               rsp_overflow
);

   logic              head_valid;
   logic              pop;
   cau_pkg::item_type head;
   cau_pkg::res_type  rsp;

   // Accept and queue request beats
   cau_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_a_re      (req_a_re),
      .req_a_im      (req_a_im),
      .req_b_re      (req_b_re),
      .req_b_im      (req_b_im),
      .pop           (pop),
      .head_valid    (head_valid),
      .head          (head)
   );

   // Execute queued beats
   cau_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_res_re      = rsp.re;
   assign rsp_res_im      = rsp.im;
   assign rsp_equal       = rsp.eq;
   assign rsp_div_by_zero = rsp.dz;
   assign rsp_overflow    = rsp.ov;

   // A beat flagged equal carries zero parts and no overflow
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal |-> rsp_res_re == 32'sd0 && rsp_res_im == 32'sd0 &&
                                 !rsp_overflow)
      else $error("compare result carries data");

   // A zero-divisor beat never overflows nor compares
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> !rsp_overflow && !rsp_equal)
      else $error("zero divisor flags inconsistent");

   // Overflow means some part sits at a range limit
   a_ov_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_res_re == cau_pkg::SAT_MAX || rsp_res_re == cau_pkg::SAT_MIN ||
         rsp_res_im == cau_pkg::SAT_MAX || rsp_res_im == cau_pkg::SAT_MIN)
      else $error("overflow without saturated part");

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench of the complex arithmetic unit with random handshake gaps.
module tb;

   localparam int FRAC = 16;
   localparam int N_RANDOM = 850;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
   } operands_type;

   typedef struct {
      logic [31:0] re, im;
      logic        eq, dz, ov;
   } outcome_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic [2:0] req_operation = '0;
   logic signed [31:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic rsp_ready = 0;
   wire req_ready, rsp_valid, rsp_equal, rsp_div_by_zero, rsp_overflow;
   wire signed [31:0] rsp_res_re, rsp_res_im;

   operands_type pending_ops[$];
   outcome_type  expected_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_gap = 0, recv_gap = 0;
   bit stimulus_done = 0;

   complex_arithmetic_unit #(.FRAC_BITS(FRAC)) uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Clamp a wide signed value to 32 bits, flagging saturation.
   function automatic logic [31:0] clamp_part(logic signed [127:0] v, ref logic ov);
      if (v > 128'sh7FFFFFFF) begin
         ov = 1;
         return cau_pkg::SAT_MAX;
      end
      if (v < -128'sh80000000) begin
         ov = 1;
         return cau_pkg::SAT_MIN;
      end
      return v[31:0];
   endfunction

   // Truncating shift toward zero.
   function automatic logic signed [127:0] trunc_shift(logic signed [127:0] v);
      logic signed [127:0] m;
      m = (v < 0) ? -v : v;
      m = m >>> FRAC;
      return (v < 0) ? -m : m;
   endfunction

   // Truncating quotient of (num << FRAC) / den, den > 0.
   function automatic logic signed [127:0] trunc_quot(logic signed [127:0] num,
                                                      logic signed [127:0] den);
      logic signed [127:0] m;
      m = (num < 0) ? -num : num;
      m = (m <<< FRAC) / den;
      return (num < 0) ? -m : m;
   endfunction

   function automatic outcome_type compute_outcome(operands_type x);
      outcome_type r;
      logic signed [127:0] a, b, c, d, den;
      logic ov;
      a = x.a_re; b = x.a_im; c = x.b_re; d = x.b_im;
      ov = 0;
      r = '{default: '0};
      case (x.op)
         cau_pkg::OP_ADD: begin
            r.re = clamp_part(a + c, ov);
            r.im = clamp_part(b + d, ov);
         end
         cau_pkg::OP_SUB: begin
            r.re = clamp_part(a - c, ov);
            r.im = clamp_part(b - d, ov);
         end
         cau_pkg::OP_MUL: begin
            r.re = clamp_part(trunc_shift(a * c - b * d), ov);
            r.im = clamp_part(trunc_shift(a * d + b * c), ov);
         end
         cau_pkg::OP_DIV: begin
            if (c == 0 && d == 0) begin
               r.re = x.a_re;
               r.im = x.a_im;
               r.dz = 1;
            end else begin
               den = c * c + d * d;
               r.re = clamp_part(trunc_quot(a * c + b * d, den), ov);
               r.im = clamp_part(trunc_quot(b * c - a * d, den), ov);
            end
         end
         cau_pkg::OP_CONJ: begin
            r.re = x.a_re;
            r.im = clamp_part(-b, ov);
         end
         cau_pkg::OP_CMP: r.eq = (a == c && b == d);
         default: ;
      endcase
      r.ov = ov;
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return 32'($signed($urandom_range(0, 8)) - 4);
         4, 5: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic add_item(logic [2:0] op, logic [31:0] ar, ai, br, bi);
      operands_type x;
      x.op = op; x.a_re = ar; x.a_im = ai; x.b_re = br; x.b_im = bi;
      pending_ops.push_back(x);
   endtask

   // Fill the directed and random stimulus.
   initial begin
      operands_type x;
      for (int op = 0; op < 8; op++) begin
         add_item(3'(op), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
         add_item(3'(op), 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0003_0000);
      end
      add_item(cau_pkg::OP_DIV, 32'h0005_0000, 32'hFFFF_0000, 0, 0);
      add_item(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
      add_item(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000);
      add_item(cau_pkg::OP_CONJ, 32'h1234_5678, 32'h8000_0000, 0, 0);
      add_item(cau_pkg::OP_CMP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678,
               32'h9ABC_DEF0);
      add_item(cau_pkg::OP_CMP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678,
               32'h9ABC_DEF1);
      add_item(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF);
      for (int i = 0; i < N_RANDOM; i++) begin
         x.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         x.a_re = pick_value(); x.a_im = pick_value();
         if (x.op == cau_pkg::OP_CMP && $urandom_range(0, 1)) begin
            x.b_re = x.a_re; x.b_im = x.a_im;
         end else begin
            x.b_re = pick_value(); x.b_im = pick_value();
         end
         pending_ops.push_back(x);
      end
   end

   // Hold reset at start, then release it.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
   end

   // Driver: present one beat at a time, hold until accepted.
   always @(posedge clock) begin
      operands_type x;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(compute_outcome(pending_ops.pop_front()));
            send_gap = pick_gap();
         end
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && pending_ops.size() != 0) begin
               x = pending_ops[0];
               req_valid <= 1;
               req_operation <= x.op;
               req_a_re <= x.a_re; req_a_im <= x.a_im;
               req_b_re <= x.b_re; req_b_im <= x.b_im;
            end else begin
               req_valid <= 0;
               if (send_gap > 0) send_gap--;
            end
         end
         if (pending_ops.size() == 0 && !(req_valid && !req_ready))
            stimulus_done = 1;
      end
   end

   // Monitor: check each response beat against the oldest expectation.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat");
            end else begin
               e = expected_results.pop_front();
               if (rsp_res_re !== e.re || rsp_res_im !== e.im || rsp_equal !== e.eq
                   || rsp_div_by_zero !== e.dz || rsp_overflow !== e.ov) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h eq%b dz%b ov%b got %h %h eq%b dz%b ov%b",
                              e.re, e.im, e.eq, e.dz, e.ov, rsp_res_re, rsp_res_im,
                              rsp_equal, rsp_div_by_zero, rsp_overflow);
               end
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 0;
            recv_gap--;
         end else begin
            rsp_ready <= 1;
            recv_gap = pick_gap();
         end
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
